// ===== design/trfp_pkg.sv =====
// Shared types and constants for the TCP reply OS fingerprint table.
package trfp_pkg;

  typedef enum logic [1:0] {
    KIND_PACKET = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  localparam logic [2:0] ST_NONE            = 3'd0;
  localparam logic [2:0] ST_SYNACK          = 3'd1;
  localparam logic [2:0] ST_RST             = 3'd2;
  localparam logic [2:0] ST_NOT_REPLY       = 3'd3;
  localparam logic [2:0] ST_RST_ZERO_WIN    = 3'd4;
  localparam logic [2:0] ST_RST_AFTER_SYNACK = 3'd5;

  localparam int DF_POS   = 14;
  localparam int CONF_CAP = 99;

  // initial TTL candidate codes: 32, 60, 64, 80, 120, 128, 255
  localparam logic [2:0] TTL_32  = 3'd0;
  localparam logic [2:0] TTL_60  = 3'd1;
  localparam logic [2:0] TTL_64  = 3'd2;
  localparam logic [2:0] TTL_80  = 3'd3;
  localparam logic [2:0] TTL_120 = 3'd4;
  localparam logic [2:0] TTL_128 = 3'd5;
  localparam logic [2:0] TTL_255 = 3'd6;

  localparam logic [3:0] VAR_UNKNOWN   = 4'd0;
  localparam logic [3:0] VAR_BSD       = 4'd1;
  localparam logic [3:0] VAR_LINUX4    = 4'd2;
  localparam logic [3:0] VAR_LINUX3    = 4'd3;
  localparam logic [3:0] VAR_LINUX26   = 4'd4;
  localparam logic [3:0] VAR_LINUX     = 4'd5;
  localparam logic [3:0] VAR_WIN_NEW   = 4'd6;
  localparam logic [3:0] VAR_WIN_MID   = 4'd7;
  localparam logic [3:0] VAR_WIN_XP    = 4'd8;
  localparam logic [3:0] VAR_IOS       = 4'd9;
  localparam logic [3:0] VAR_ASA       = 4'd10;
  localparam logic [3:0] VAR_EMBEDDED  = 4'd11;

  typedef struct packed {
    logic [5:0]  opt_len;
    logic        df;
    logic [15:0] window;
    logic [2:0]  ttl_idx;
  } fp_t;

  localparam int FP_W = $bits(fp_t);

  typedef struct packed {
    logic [7:0] host;
    logic [2:0] status;
    logic       known;
    logic       we;
    fp_t        fp;
  } req_t;

  // nearest candidate, earlier one wins a tie
  function automatic logic [2:0] nearest_ttl(input logic [7:0] rx);
    logic [2:0] idx;
    if (rx <= 8'd46) idx = TTL_32;
    else if (rx <= 8'd62) idx = TTL_60;
    else if (rx <= 8'd72) idx = TTL_64;
    else if (rx <= 8'd100) idx = TTL_80;
    else if (rx <= 8'd124) idx = TTL_120;
    else if (rx <= 8'd191) idx = TTL_128;
    else idx = TTL_255;
    return idx;
  endfunction

endpackage

// ===== design/trfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module trfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/trfp_front.sv =====
// Front end: accepts requests, decides update and status, owns the valid/SYN+ACK marks.
module trfp_front
  import trfp_pkg::*;
#(
  parameter int HOSTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [1:0]  kind,
  input  logic [7:0]  host,
  input  logic [7:0]  ttl,
  input  logic [15:0] window,
  input  logic        syn,
  input  logic        ack,
  input  logic        rst_req,
  input  logic [15:0] frag_word,
  input  logic [3:0]  data_offset,
  output req_t        req
);

  localparam int DEPTH = (HOSTS < 256) ? HOSTS : 256;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] synack_mark;

  logic          in_range;
  logic [AW-1:0] idx;
  logic          cur_valid;
  logic          cur_synack;
  logic          synack;
  logic          set_entry;
  logic [5:0]    opt_len;

  assign in_range   = {5'd0, host} < 13'(HOSTS);
  assign idx        = host[AW-1:0];
  assign cur_valid  = in_range && valid[idx];
  assign cur_synack = in_range && synack_mark[idx];
  assign synack     = syn & ack;
  assign opt_len    = (data_offset >= 4'd5) ? {data_offset - 4'd5, 2'b00} : 6'd0;

  always_comb begin
    req              = '0;
    req.host         = host;
    req.fp.ttl_idx   = nearest_ttl(ttl);
    req.fp.window    = window;
    req.fp.df        = frag_word[DF_POS];
    req.fp.opt_len   = opt_len;
    set_entry        = 1'b0;
    unique case (kind)
      KIND_PACKET: begin
        if (in_range) begin
          if (!synack && !rst_req) begin
            req.status = ST_NOT_REPLY;
          end else if (rst_req && window == 16'd0) begin
            req.status = ST_RST_ZERO_WIN;
          end else if (synack) begin
            req.status = ST_SYNACK;
            set_entry  = 1'b1;
          end else if (!cur_synack) begin
            req.status = ST_RST;
            set_entry  = 1'b1;
          end else begin
            req.status = ST_RST_AFTER_SYNACK;
          end
          req.we    = set_entry;
          req.known = cur_valid | set_entry;
        end
      end
      KIND_REPORT: begin
        req.known = cur_valid;
      end
      KIND_CLEAR: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      synack_mark <= '0;
    end else if (push) begin
      if (kind == KIND_CLEAR) begin
        valid       <= '0;
        synack_mark <= '0;
      end else if (set_entry) begin
        valid[idx]       <= 1'b1;
        synack_mark[idx] <= synack;
      end
    end
  end

endmodule

// ===== design/trfp_queue.sv =====
// Two-entry request queue between front and back end.
module trfp_queue
  import trfp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t push_req,
  input  logic pop,
  output logic not_empty,
  output logic full,
  output req_t head_req
);

  req_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign not_empty = count != 2'd0;
  assign full      = count == 2'd2;
  assign head_req  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== design/trfp_back.sv =====
// Back end: table read/write, classification and result register.
module trfp_back
  import trfp_pkg::*;
#(
  parameter int HOSTS = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_vld,
  input  req_t       req,
  output logic       pop,
  output logic       done,
  output logic [7:0] host_out,
  output logic [2:0] status,
  output logic       known,
  output logic [3:0] variant,
  output logic [6:0] confidence
);

  localparam int DEPTH = (HOSTS < 256) ? HOSTS : 256;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic            s1_vld;
  req_t            s1_req;
  logic [FP_W-1:0] rdata;
  fp_t             fp;
  logic [3:0]      var_c;
  logic [6:0]      base;
  logic [6:0]      extra;
  logic [6:0]      total;

  assign pop = req_vld;

  trfp_ram #(
    .WIDTH(FP_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (pop && req.we),
    .waddr(req.host[AW-1:0]),
    .wdata(req.fp),
    .raddr(req.host[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_req <= req;
    end
  end

  // a write in this request forwards its own fingerprint
  assign fp = s1_req.we ? s1_req.fp : fp_t'(rdata);

  always_comb begin
    var_c = VAR_UNKNOWN;
    extra = 7'd0;
    unique case (fp.ttl_idx)
      TTL_32: begin
        base = 7'd30;
      end
      TTL_64: begin
        base = 7'd45;
        if (fp.opt_len >= 6'd16) begin
          var_c = VAR_BSD;
          extra = 7'd25;
        end else if (fp.window >= 16'd32768) begin
          var_c = VAR_LINUX4;
          extra = (fp.opt_len >= 6'd12) ? 7'd30 : ((fp.opt_len >= 6'd4) ? 7'd25 : 7'd20);
        end else if (fp.window >= 16'd16384) begin
          var_c = VAR_LINUX3;
          extra = 7'd15;
        end else if (fp.window >= 16'd8192) begin
          var_c = VAR_LINUX26;
          extra = 7'd10;
        end else begin
          var_c = VAR_LINUX;
          extra = 7'd5;
        end
      end
      TTL_128: begin
        base = 7'd45;
        if (fp.window >= 16'd64000) begin
          var_c = VAR_WIN_NEW;
          extra = 7'd25;
        end else if (fp.window >= 16'd16000) begin
          var_c = VAR_WIN_MID;
          extra = 7'd20;
        end else begin
          var_c = VAR_WIN_XP;
          extra = 7'd15;
        end
      end
      TTL_255: begin
        base = 7'd45;
        if (fp.window <= 16'd4096) begin
          var_c = VAR_IOS;
          extra = 7'd25;
        end else if (fp.window <= 16'd8192) begin
          var_c = VAR_ASA;
          extra = 7'd20;
        end else begin
          var_c = VAR_EMBEDDED;
          extra = 7'd15;
        end
      end
      default: begin
        base = 7'd15;
      end
    endcase
    total = base + extra + (fp.df ? 7'd5 : 7'd0);
    if (total > 7'(CONF_CAP)) total = 7'(CONF_CAP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld) begin
      host_out   <= s1_req.host;
      status     <= s1_req.status;
      known      <= s1_req.known;
      variant    <= s1_req.known ? var_c : VAR_UNKNOWN;
      confidence <= s1_req.known ? total : 7'd0;
    end
  end

endmodule

// ===== design/tcp_reply_os_fingerprint_table_top.sv =====
// Top level of the TCP reply OS fingerprint table.
// The result strobe (done) follows an accepted request through the queue, the s1 register and the result register.
// Throughput: one request per cycle; the back end pops the queue whenever it holds an entry, so busy stays low.
// The fingerprint RAM's single write port and registered read set the two-stage back end.
// Reset (rst, synchronous) clears all host marks, the queue and the result strobe.
module tcp_reply_os_fingerprint_table_top
  import trfp_pkg::*;
#(
  parameter int HOSTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [7:0]  host,
  input  logic [7:0]  ttl,
  input  logic [15:0] window,
  input  logic        syn,
  input  logic        ack,
  input  logic        rst_req,
  input  logic [15:0] frag_word,
  input  logic [3:0]  data_offset,
  output logic        done,
  output logic [7:0]  host_out,
  output logic [2:0]  status,
  output logic        known,
  output logic [3:0]  variant,
  output logic [6:0]  confidence
);

  logic push;
  logic pop;
  logic q_vld;
  logic q_full;
  req_t front_req;
  req_t head_req;

  assign busy = q_full;
  assign push = start && !busy;

  trfp_front #(.HOSTS(HOSTS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .kind       (kind),
    .host       (host),
    .ttl        (ttl),
    .window     (window),
    .syn        (syn),
    .ack        (ack),
    .rst_req    (rst_req),
    .frag_word  (frag_word),
    .data_offset(data_offset),
    .req        (front_req)
  );

  trfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (front_req),
    .pop      (pop),
    .not_empty(q_vld),
    .full     (q_full),
    .head_req (head_req)
  );

  trfp_back #(.HOSTS(HOSTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .req_vld   (q_vld),
    .req       (head_req),
    .pop       (pop),
    .done      (done),
    .host_out  (host_out),
    .status    (status),
    .known     (known),
    .variant   (variant),
    .confidence(confidence)
  );

endmodule

// ===== design/trfp_checker.sv =====
// Port-level checker for the fingerprint table, bound to the top level.
module trfp_checker
  import trfp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [2:0] status,
  input logic       known,
  input logic [3:0] variant,
  input logic [6:0] confidence
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("accepted request produced no result");

  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !known) |-> (variant == VAR_UNKNOWN && confidence == 7'd0))
    else $error("unknown host with classification");

  a_store_known: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_SYNACK || status == ST_RST)) |-> known)
    else $error("stored entry not reported as known");

  a_conf_cap: assert property (@(posedge clk) disable iff (rst)
    done |-> confidence <= 7'(CONF_CAP))
    else $error("confidence above cap");

endmodule

bind tcp_reply_os_fingerprint_table_top trfp_checker u_trfp_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .status    (status),
  .known     (known),
  .variant   (variant),
  .confidence(confidence)
);
